@@ hdl/fce_pkg.sv @@
//------------------------------------------------------------------------------
// fce_pkg
// Shared constants, codes and control types of the frame checksum channel
// extractor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fce_pkg;

  localparam int FRAME_BYTES = 20;
  localparam int CHANNELS    = 8;
  localparam int MAX_OUT     = 8;
  // results emitted for a good frame
  localparam int TOTAL       = (CHANNELS < MAX_OUT) ? CHANNELS : MAX_OUT;

  localparam int CNT_W   = $clog2(FRAME_BYTES + 2);
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 16;
  localparam int VALUE_W = 12;
  localparam int CHIDX_W = 3;
  localparam int FLAG_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [VALUE_W-1:0] VALUE_MASK = 12'hFFF;

  localparam logic [BYTE_W-1:0] FIRST_HDR_RESET  = 8'd170;
  localparam logic [BYTE_W-1:0] SECOND_HDR_RESET = 8'd85;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HDR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HDR = 1'd1;

  // sticky flag bit positions
  localparam int FLAG_FRAMING = 0;
  localparam int FLAG_CSUM    = 1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LEN  = 2'd1,
    STAT_HDR  = 2'd2,
    STAT_CSUM = 2'd3
  } status_e;

  typedef enum logic {
    CS_RECV,
    CS_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic in_ready;   // input side may transfer
    logic take;       // input byte transferred this cycle
    logic load_next;  // load next channel into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_end;
    logic out_busy;    // output register holds a result not taken this cycle
    logic frame_pass;  // final byte on input completes a good frame
    logic drain_last;  // next channel to load is the last one
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/fce_if.sv @@
//------------------------------------------------------------------------------
// fce_in_if / fce_out_if
// Valid/ready channels for received bytes and extracted results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fce_in_if;
  logic                       valid;
  logic                       ready;
  logic [fce_pkg::BYTE_W-1:0] rx_byte;
  logic                       frame_end;
  logic                       clear_errors;

  modport source (output valid, output rx_byte, output frame_end,
                  output clear_errors, input ready);
  modport sink   (input valid, input rx_byte, input frame_end,
                  input clear_errors, output ready);
endinterface

interface fce_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fce_pkg::CHIDX_W-1:0] channel_index;
  logic [fce_pkg::VALUE_W-1:0] channel_value;
  logic [fce_pkg::FLAG_W-1:0]  error_flags;
  logic                        last_result;

  modport source (output valid, output status, output channel_index,
                  output channel_value, output error_flags, output last_result,
                  input ready);
  modport sink   (input valid, input status, input channel_index,
                  input channel_value, input error_flags, input last_result,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/fce_ctrl.sv @@
//------------------------------------------------------------------------------
// fce_ctrl
// Controller: receive state and channel drain sequencing.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fce_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  fce_pkg::dp_stat_t stat_i,
  output fce_pkg::dp_cmd_t  cmd_o
);

  fce_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fce_pkg::CS_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      fce_pkg::CS_RECV: begin
        // non-final bytes need no output slot
        cmd_o.in_ready = !stat_i.out_busy || !stat_i.in_end;
        cmd_o.take     = stat_i.in_valid && cmd_o.in_ready;
        if (cmd_o.take && stat_i.in_end && stat_i.frame_pass && (fce_pkg::TOTAL > 1)) begin
          state_d = fce_pkg::CS_DRAIN;
        end
      end
      fce_pkg::CS_DRAIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_next = 1'b1;
          if (stat_i.drain_last) begin
            state_d = fce_pkg::CS_RECV;
          end
        end
      end
      default: begin
        state_d = fce_pkg::CS_RECV;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/fce_datapath.sv @@
//------------------------------------------------------------------------------
// fce_datapath
// Byte counter, running sum, header check, channel store and output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fce_datapath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire [fce_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [fce_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  fce_in_if.sink                             in_bus,
  fce_out_if.source                          out_bus,
  input  fce_pkg::dp_cmd_t                   cmd_i,
  output fce_pkg::dp_stat_t                  stat_o
);

  localparam int CNT_W = fce_pkg::CNT_W;

  // configuration
  logic [fce_pkg::BYTE_W-1:0] hdr0_q, hdr1_q;

  // per-frame state
  logic [CNT_W-1:0]           pos_q, pos_d;
  logic [fce_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic                       hdr_good_q, hdr_good_d;
  logic [fce_pkg::BYTE_W-1:0] trl_lo_q, trl_lo_d;
  logic [fce_pkg::BYTE_W-1:0] pend_lo_q, pend_lo_d;
  logic [fce_pkg::FLAG_W-1:0] sticky_q, sticky_d;

  logic [fce_pkg::VALUE_W-1:0] store_q [fce_pkg::CHANNELS];

  logic [fce_pkg::IDX_W-1:0]  drain_idx_q, drain_idx_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  fce_pkg::status_e            out_status_q, out_status_d;
  logic [fce_pkg::CHIDX_W-1:0] out_idx_q, out_idx_d;
  logic [fce_pkg::VALUE_W-1:0] out_val_q, out_val_d;
  logic [fce_pkg::FLAG_W-1:0]  out_flags_q, out_flags_d;
  logic                        out_last_q, out_last_d;

  logic [CNT_W-1:0]            cnt_next;
  logic [CNT_W-1:0]            pos_m2;
  logic [CNT_W-1:0]            ch_full;
  logic                        store_we;
  logic [fce_pkg::CH_W-1:0]    store_waddr;
  logic [fce_pkg::VALUE_W-1:0] store_wdata;
  logic                        len_ok, csum_ok;
  fce_pkg::status_e            final_status;

  assign in_bus.ready = cmd_i.in_ready;

  assign cnt_next = (pos_q >= CNT_W'(fce_pkg::FRAME_BYTES + 1)) ? pos_q : pos_q + 1'b1;
  assign pos_m2   = pos_q - CNT_W'(2);
  assign ch_full  = pos_m2 >> 1;

  assign len_ok  = (cnt_next == CNT_W'(fce_pkg::FRAME_BYTES));
  assign csum_ok = (~sum_q == {in_bus.rx_byte, trl_lo_q});

  always_comb begin
    if (!len_ok) begin
      final_status = fce_pkg::STAT_LEN;
    end else if (!hdr_good_q) begin
      final_status = fce_pkg::STAT_HDR;
    end else if (!csum_ok) begin
      final_status = fce_pkg::STAT_CSUM;
    end else begin
      final_status = fce_pkg::STAT_OK;
    end
  end

  assign stat_o.in_valid   = in_bus.valid;
  assign stat_o.in_end     = in_bus.frame_end;
  assign stat_o.out_busy   = out_valid_q && !out_bus.ready;
  assign stat_o.frame_pass = (final_status == fce_pkg::STAT_OK);
  assign stat_o.drain_last = (drain_idx_q == fce_pkg::IDX_W'(fce_pkg::TOTAL - 1));

  assign store_wdata = fce_pkg::VALUE_W'({in_bus.rx_byte, pend_lo_q}) & fce_pkg::VALUE_MASK;
  assign store_waddr = fce_pkg::CH_W'(ch_full);

  // per-frame byte handling
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    hdr_good_d = hdr_good_q;
    trl_lo_d   = trl_lo_q;
    pend_lo_d  = pend_lo_q;
    sticky_d   = sticky_q;
    store_we   = 1'b0;
    if (cmd_i.take) begin
      if (in_bus.clear_errors) begin
        sticky_d = '0;
      end
      if (pos_q == CNT_W'(0) && in_bus.rx_byte != hdr0_q) begin
        hdr_good_d = 1'b0;
      end
      if (pos_q == CNT_W'(1) && in_bus.rx_byte != hdr1_q) begin
        hdr_good_d = 1'b0;
      end
      if (pos_q < CNT_W'(fce_pkg::FRAME_BYTES - 2)) begin
        sum_d = sum_q + fce_pkg::SUM_W'(in_bus.rx_byte);
        if (pos_q >= CNT_W'(2)) begin
          if (!pos_q[0]) begin
            pend_lo_d = in_bus.rx_byte;
          end else if (int'(ch_full) < fce_pkg::CHANNELS) begin
            store_we = 1'b1;
          end
        end
      end else if (pos_q == CNT_W'(fce_pkg::FRAME_BYTES - 2)) begin
        trl_lo_d = in_bus.rx_byte;
      end
      pos_d = cnt_next;
      if (in_bus.frame_end) begin
        if (final_status == fce_pkg::STAT_HDR) begin
          sticky_d[fce_pkg::FLAG_FRAMING] = 1'b1;
        end
        if (final_status == fce_pkg::STAT_CSUM) begin
          sticky_d[fce_pkg::FLAG_CSUM] = 1'b1;
        end
        pos_d      = '0;
        sum_d      = '0;
        hdr_good_d = 1'b1;
        trl_lo_d   = '0;
        pend_lo_d  = '0;
      end
    end
  end

  // result loading
  always_comb begin
    out_valid_d  = out_valid_q && !out_bus.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_val_d    = out_val_q;
    out_flags_d  = out_flags_q;
    out_last_d   = out_last_q;
    drain_idx_d  = drain_idx_q;
    if (cmd_i.take && in_bus.frame_end) begin
      out_valid_d  = 1'b1;
      out_status_d = final_status;
      out_idx_d    = '0;
      out_flags_d  = sticky_d;
      if (final_status == fce_pkg::STAT_OK) begin
        out_val_d  = store_q[0];
        out_last_d = (fce_pkg::TOTAL == 1);
      end else begin
        out_val_d  = '0;
        out_last_d = 1'b1;
      end
      drain_idx_d = fce_pkg::IDX_W'(1);
    end else if (cmd_i.load_next) begin
      out_valid_d  = 1'b1;
      out_status_d = fce_pkg::STAT_OK;
      out_idx_d    = fce_pkg::CHIDX_W'(drain_idx_q);
      out_val_d    = store_q[fce_pkg::CH_W'(drain_idx_q)];
      out_flags_d  = sticky_q;
      out_last_d   = stat_o.drain_last;
      drain_idx_d  = drain_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q      <= fce_pkg::FIRST_HDR_RESET;
      hdr1_q      <= fce_pkg::SECOND_HDR_RESET;
      pos_q       <= '0;
      sum_q       <= '0;
      hdr_good_q  <= 1'b1;
      trl_lo_q    <= '0;
      pend_lo_q   <= '0;
      sticky_q    <= '0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fce_pkg::CFG_FIRST_HDR) begin
          hdr0_q <= cfg_data_i;
        end
        if (cfg_idx_i == fce_pkg::CFG_SECOND_HDR) begin
          hdr1_q <= cfg_data_i;
        end
      end
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      hdr_good_q  <= hdr_good_d;
      trl_lo_q    <= trl_lo_d;
      pend_lo_q   <= pend_lo_d;
      sticky_q    <= sticky_d;
      drain_idx_q <= drain_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_waddr] <= store_wdata;
    end
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_val_q    <= out_val_d;
    out_flags_q  <= out_flags_d;
    out_last_q   <= out_last_d;
  end

  assign out_bus.valid         = out_valid_q;
  assign out_bus.status        = out_status_q;
  assign out_bus.channel_index = out_idx_q;
  assign out_bus.channel_value = out_val_q;
  assign out_bus.error_flags   = out_flags_q;
  assign out_bus.last_result   = out_last_q;

endmodule

`default_nettype wire

@@ hdl/frame_checksum_channel_extractor_core.sv @@
// Frame checksum channel extractor. Takes one received byte per cycle on
// in_bus when not stalled (frame_end marks the last byte) and reports each
// frame on out_bus: one error result (wrong length, header mismatch or
// checksum mismatch), or one result per channel for a good frame. Outside a
// drain a non-final byte is taken even while a result waits; a final byte
// waits for a free result register. After a good frame's final byte the
// remaining channels pass one at a time from the channel store through the
// single result register, no byte being taken; that drain sets the rate of
// good frames. Header registers (cfg_we_i / cfg_idx_i / cfg_data_i) must be
// written only while the block is idle; the block does not enforce it.
//------------------------------------------------------------------------------
// frame_checksum_channel_extractor_core
// Top level: controller and datapath of the frame checksum channel extractor.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_checksum_channel_extractor_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [fce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [fce_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  fce_in_if.sink                         in_bus,
  fce_out_if.source                      out_bus
);

  fce_pkg::dp_cmd_t  cmd;
  fce_pkg::dp_stat_t stat;

  fce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fce_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

`default_nettype wire

@@ hdl/fce_checker.sv @@
//------------------------------------------------------------------------------
// fce_checker
// Port-level checks of the frame checksum channel extractor, bound to the top.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fce_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [1:0]                      out_status,
  input wire [fce_pkg::CHIDX_W-1:0]     out_channel_index,
  input wire [fce_pkg::VALUE_W-1:0]     out_channel_value,
  input wire [fce_pkg::FLAG_W-1:0]      out_error_flags,
  input wire                            out_last_result
);

  // error results are single, empty and final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != fce_pkg::STAT_OK |->
      out_last_result && out_channel_index == '0 && out_channel_value == '0)
    else $error("error result not final or not empty");

  // sticky flag matches the error reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == fce_pkg::STAT_HDR) |->
      out_error_flags[fce_pkg::FLAG_FRAMING])
    else $error("header error without framing flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_status == fce_pkg::STAT_CSUM) |->
      out_error_flags[fce_pkg::FLAG_CSUM])
    else $error("checksum error without checksum flag");

  // no byte taken while a frame's channels are still draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status == fce_pkg::STAT_OK && !out_last_result |-> !in_ready)
    else $error("input ready during channel drain");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      out_valid && $stable(out_channel_value) && $stable(out_channel_index) &&
      $stable(out_status) && $stable(out_last_result))
    else $error("stalled result changed");

endmodule

bind frame_checksum_channel_extractor_core fce_checker u_fce_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_status        (out_bus.status),
  .out_channel_index (out_bus.channel_index),
  .out_channel_value (out_bus.channel_value),
  .out_error_flags   (out_bus.error_flags),
  .out_last_result   (out_bus.last_result)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// Frame-level check of the frame checksum channel extractor: byte streams of
// good, truncated, overlong, bad-header and bad-checksum frames are pushed
// through the input channel. Every accepted byte updates a local model of the
// block, and each result that comes out is compared with the oldest
// outstanding prediction. Both channels idle at random, with one long hold
// on the result side to back the block up.
//------------------------------------------------------------------------------

module testbench;

  localparam int LIMIT = 200000;

  typedef struct packed {
    logic [fce_pkg::BYTE_W-1:0] data;
    logic                       fend;
    logic                       clr;
  } rx_item_t;

  typedef struct packed {
    fce_pkg::status_e             status;
    logic [fce_pkg::CHIDX_W-1:0]  index;
    logic [fce_pkg::VALUE_W-1:0]  value;
    logic [fce_pkg::FLAG_W-1:0]   flags;
    logic                         last;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [fce_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fce_pkg::CFG_DATA_W-1:0] cfg_data_i;

  fce_in_if  in_bus ();
  fce_out_if out_bus ();

  frame_checksum_channel_extractor_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_bus     (in_bus),
    .out_bus    (out_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rx_item_t rx_stream[$];
  report_t  report_queue[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_off = 1'b0;
  int accepted = 0;
  int mismatches = 0;
  int cycles = 0;

  // local copy of block state
  logic [fce_pkg::BYTE_W-1:0]  hdr0 = fce_pkg::FIRST_HDR_RESET;
  logic [fce_pkg::BYTE_W-1:0]  hdr1 = fce_pkg::SECOND_HDR_RESET;
  int                          rx_count = 0;
  logic [fce_pkg::SUM_W-1:0]   csum = '0;
  logic                        hdr_ok = 1'b1;
  logic [fce_pkg::BYTE_W-1:0]  trail_lo = '0;
  logic [fce_pkg::BYTE_W-1:0]  low_byte = '0;
  logic [fce_pkg::VALUE_W-1:0] chan_word [fce_pkg::CHANNELS];
  logic [fce_pkg::FLAG_W-1:0]  sticky = '0;

  initial begin
    for (int i = 0; i < fce_pkg::CHANNELS; i++) chan_word[i] = '0;
  end

  task automatic predict_reports(input rx_item_t it);
    int pos;
    int cnt;
    logic [fce_pkg::SUM_W-1:0] want;
    logic [fce_pkg::SUM_W-1:0] got;
    report_t r;
    pos = rx_count;
    if (it.clr) sticky = '0;
    if (pos < fce_pkg::FRAME_BYTES) begin
      if (pos == 0 && it.data != hdr0) hdr_ok = 1'b0;
      if (pos == 1 && it.data != hdr1) hdr_ok = 1'b0;
      if (pos < fce_pkg::FRAME_BYTES - 2) begin
        csum = csum + fce_pkg::SUM_W'(it.data);
        if (pos >= 2) begin
          if (pos % 2 == 0) begin
            low_byte = it.data;
          end else if ((pos - 2) / 2 < fce_pkg::CHANNELS) begin
            chan_word[(pos - 2) / 2] =
              fce_pkg::VALUE_W'({it.data, low_byte}) & fce_pkg::VALUE_MASK;
          end
        end
      end else if (pos == fce_pkg::FRAME_BYTES - 2) begin
        trail_lo = it.data;
      end
    end
    cnt = pos + 1;
    if (cnt > fce_pkg::FRAME_BYTES + 1) cnt = fce_pkg::FRAME_BYTES + 1;
    rx_count = cnt;
    if (it.fend) begin
      r = '0;
      r.last = 1'b1;
      want = ~csum;
      got = {it.data, trail_lo};
      if (cnt != fce_pkg::FRAME_BYTES) begin
        r.status = fce_pkg::STAT_LEN;
      end else if (!hdr_ok) begin
        sticky[fce_pkg::FLAG_FRAMING] = 1'b1;
        r.status = fce_pkg::STAT_HDR;
      end else if (want != got) begin
        sticky[fce_pkg::FLAG_CSUM] = 1'b1;
        r.status = fce_pkg::STAT_CSUM;
      end else begin
        r.status = fce_pkg::STAT_OK;
      end
      if (r.status != fce_pkg::STAT_OK) begin
        r.flags = sticky;
        report_queue.push_back(r);
      end else begin
        for (int k = 0; k < fce_pkg::TOTAL; k++) begin
          r.index = fce_pkg::CHIDX_W'(k);
          r.value = chan_word[k];
          r.flags = sticky;
          r.last = (k == fce_pkg::TOTAL - 1);
          report_queue.push_back(r);
        end
      end
      rx_count = 0;
      csum = '0;
      hdr_ok = 1'b1;
      trail_lo = '0;
      low_byte = '0;
    end
  endtask

  // driver: a byte stays on the bus until it is transferred
  always @(posedge clk_i) begin
    rx_item_t it;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        it.data = in_bus.rx_byte;
        it.fend = in_bus.frame_end;
        it.clr  = in_bus.clear_errors;
        predict_reports(it);
        accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          it = rx_stream.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.rx_byte      <= it.data;
          in_bus.frame_end    <= it.fend;
          in_bus.clear_errors <= it.clr;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status = fce_pkg::status_e'(out_bus.status);
        got.index  = out_bus.channel_index;
        got.value  = out_bus.channel_value;
        got.flags  = out_bus.error_flags;
        got.last   = out_bus.last_result;
        if (report_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d idx %0d value %h flags %b last %b",
                     got.status, got.index, got.value, got.flags, got.last);
        end else begin
          want = report_queue.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.value !== want.value || got.flags !== want.flags ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: exp status %0d idx %0d value %h flags %b last %b",
                       want.status, want.index, want.value, want.flags, want.last);
              $display("                 got status %0d idx %0d value %h flags %b last %b",
                       got.status, got.index, got.value, got.flags, got.last);
            end
          end
        end
      end
      out_bus.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** frame_checksum_channel_extractor_core: FAILED **");
      $finish;
    end
  end

  // long result-side hold while the sender keeps streaming
  initial begin
    while (accepted < 260) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (120) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] fb[$]);
    rx_item_t it;
    for (int i = 0; i < fb.size(); i++) begin
      it.data = fb[i];
      it.fend = (i == fb.size() - 1);
      it.clr  = ($urandom_range(0, 7) == 0);
      rx_stream.push_back(it);
    end
  endtask

  // well-formed frame with the current headers and a matching trailer
  task automatic good_frame(output logic [7:0] fb[$]);
    logic [fce_pkg::SUM_W-1:0] s;
    fb = {};
    fb.push_back(hdr0);
    fb.push_back(hdr1);
    for (int p = 2; p < fce_pkg::FRAME_BYTES - 2; p++) fb.push_back(rand_byte());
    s = '0;
    foreach (fb[i]) s = s + fce_pkg::SUM_W'(fb[i]);
    s = ~s;
    fb.push_back(s[7:0]);
    fb.push_back(s[15:8]);
  endtask

  task automatic random_frames(input int amount);
    logic [7:0] fb[$];
    int kind;
    int n;
    int added;
    added = 0;
    while (added < amount) begin
      good_frame(fb);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // keep as is
      end else if (kind < 65) begin
        n = $urandom_range(0, 1);
        fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 75) begin
        n = $urandom_range(2, fce_pkg::FRAME_BYTES - 1);
        fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind < 85) begin
        n = $urandom_range(1, fce_pkg::FRAME_BYTES - 1);
        while (fb.size() > n) void'(fb.pop_back());
      end else if (kind < 93) begin
        // overlong: count saturates, extra bytes are dropped
        n = $urandom_range(1, 8);
        repeat (n) fb.push_back(rand_byte());
      end else begin
        n = $urandom_range(1, 24);
        fb = {};
        repeat (n) fb.push_back(rand_byte());
        if ($urandom_range(0, 1)) fb[0] = hdr0;
      end
      send_frame(fb);
      added += fb.size();
    end
  endtask

  // sampled between edges, once the driver has settled the bus
  task automatic wait_idle();
    while (rx_stream.size() != 0 || in_bus.valid || report_queue.size() != 0)
      @(negedge clk_i);
    repeat (fce_pkg::TOTAL + 2) @(posedge clk_i);
  endtask

  task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= fce_pkg::CFG_FIRST_HDR;
    cfg_data_i <= h0;
    @(posedge clk_i);
    cfg_idx_i  <= fce_pkg::CFG_SECOND_HDR;
    cfg_data_i <= h1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr0 = h0;
    hdr1 = h1;
  endtask

  initial begin
    logic [7:0] fb[$];
    logic [fce_pkg::SUM_W-1:0] s;
    rx_item_t it;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_bus.valid        = 1'b0;
    in_bus.rx_byte      = '0;
    in_bus.frame_end    = 1'b0;
    in_bus.clear_errors = 1'b0;
    out_bus.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct <= 9;
    recv_idle_pct <= 65;
    @(posedge clk_i);

    // directed: reset headers, channel words at the value extremes
    fb = {hdr0, hdr1, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'hF0,
          8'h55, 8'hAA, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h34, 8'h12};
    s = '0;
    foreach (fb[i]) s = s + fce_pkg::SUM_W'(fb[i]);
    s = ~s;
    fb.push_back(s[7:0]);
    fb.push_back(s[15:8]);
    send_frame(fb);
    // one-byte frame with error clear
    it.data = 8'hFF;
    it.fend = 1'b1;
    it.clr  = 1'b1;
    rx_stream.push_back(it);
    wait_idle();

    set_headers(8'h00, 8'hFF);
    random_frames(100);
    wait_idle();

    set_headers(8'hFF, 8'h00);
    send_idle_pct <= 65;
    recv_idle_pct <= 9;
    random_frames(100);
    wait_idle();

    set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    random_frames(100);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** frame_checksum_channel_extractor_core: PASSED **");
    end else begin
      $display("** frame_checksum_channel_extractor_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fce_pkg.sv
hdl/fce_if.sv
hdl/fce_ctrl.sv
hdl/fce_datapath.sv
hdl/frame_checksum_channel_extractor_core.sv
hdl/fce_checker.sv
tb/testbench.sv
